@@ hdl/priority_pick_with_aging_boost_top_macros.svh @@
// Assertion macros for the checker file of the priority picker.
`ifndef PRIORITY_PICK_WITH_AGING_BOOST_TOP_MACROS_SVH
`define PRIORITY_PICK_WITH_AGING_BOOST_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, held off during reset
`define PPAB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppab check failed");

// Next-cycle implication, sampled on clk_i, held off during reset
`define PPAB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppab check failed");

`endif

@@ hdl/ppab_pkg.sv @@
// Shared types and constants of the priority level picker.
`timescale 1ns / 1ps
package ppab_pkg;

  localparam int MaxLevelsDef = 16;
  localparam int MaskLevels   = 16;
  localparam int AgeW         = 16;
  localparam int LevelW       = 4;
  localparam int CountW       = 5;

  localparam logic signed [AgeW-1:0] AgeMax = 16'sh7FFF;
  localparam logic signed [AgeW-1:0] AgeMin = 16'sh8000;

  // Configuration register indexes
  localparam logic RegLevelCount    = 1'b0;
  localparam logic RegBoostAgeStart = 1'b1;

  // Input commands
  localparam logic CmdTick = 1'b0;
  localparam logic CmdPick = 1'b1;

  // Operations of the shared step unit
  typedef enum logic [1:0] {
    AluSubGe   = 2'd0,
    AluInc     = 2'd1,
    AluIncWrap = 2'd2
  } ppab_alu_op_e;

  // Job handed to the scan sequencer
  typedef struct packed {
    logic                cmd;
    logic                boost;
    logic [MaskLevels-1:0] mask;
    logic [CountW-1:0]   n;
    logic [LevelW-1:0]   ptr;
  } ppab_req_t;

  // Outcome of one item
  typedef struct packed {
    logic              found;
    logic [LevelW-1:0] level;
    logic              was_boost;
    logic [LevelW-1:0] ptr_next;
  } ppab_res_t;

endpackage

@@ hdl/priority_pick_with_aging_boost_top.sv @@
// Top level of the priority level picker with aging boost.
`timescale 1ns / 1ps
// Each transaction on the slave side is a tick (tuser 0) or a pick (tuser 1)
// and yields exactly one result transaction. The block takes one item at a
// time and drops tready until that item's result sits in the output register.
// A tick skips the scan. A normal pick has the scan sequencer test one level
// per cycle from level 0. A boost pick first takes R subtract steps in the
// shared unit, where R (0 to 15) is the number needed to bring the boost
// pointer below N-1 (R is at most 1 unless level_count was changed after the
// pointer advanced), and then scans from the level after the reduced pointer.
// Configuration writes land at once; level_count is limited to MAX_LEVELS
// and to 16, a zero count acts as one.
module priority_pick_with_aging_boost_top #(
  parameter int MAX_LEVELS = ppab_pkg::MaxLevelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] nonempty_mask
  input  logic        s_axis_tuser,   // [0] cmd
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] found, [4:1] level, [5] was_boost, [7:6] zero
);
  import ppab_pkg::*;

  localparam int LevelCap = (MAX_LEVELS < MaskLevels) ? MAX_LEVELS : MaskLevels;

  logic [CountW-1:0]      level_count_q;
  logic signed [AgeW-1:0] start_q;
  logic signed [AgeW-1:0] age_q, age_d;
  logic [LevelW-1:0]      ptr_q, ptr_d;

  logic              out_valid_q;
  logic              out_found_q;
  logic [LevelW-1:0] out_level_q;
  logic              out_boost_q;

  logic              in_acc;
  logic [CountW-1:0] n_eff;
  logic              age_due;
  logic              scan_idle;
  logic              res_ready;
  logic              res_valid;
  ppab_req_t         req;
  ppab_res_t         res;

  // Clamp the level count to the usable range
  always_comb begin
    if (level_count_q == '0) begin
      n_eff = CountW'(1);
    end else if (level_count_q > CountW'(LevelCap)) begin
      n_eff = CountW'(LevelCap);
    end else begin
      n_eff = level_count_q;
    end
  end

  assign age_due = age_q[AgeW-1] || (age_q == '0);
  assign in_acc  = s_axis_tvalid && s_axis_tready;

  assign req.cmd   = s_axis_tuser;
  assign req.boost = (s_axis_tuser == CmdPick) && (n_eff > CountW'(1)) && age_due;
  assign req.mask  = s_axis_tdata;
  assign req.n     = n_eff;
  assign req.ptr   = ptr_q;

  assign res_ready = !out_valid_q || m_axis_tready;

  ppab_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .req_i       (req),
    .idle_o      (scan_idle),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign s_axis_tready = scan_idle;

  // Update age and boost pointer
  always_comb begin
    age_d = age_q;
    ptr_d = ptr_q;
    if (cfg_we_i && (cfg_idx_i == RegBoostAgeStart)) begin
      age_d = ($signed(cfg_data_i) == AgeMin) ? AgeMin : ($signed(cfg_data_i) - 16'sd1);
      ptr_d = LevelW'(1);
    end else begin
      if (in_acc) begin
        if (req.cmd == CmdTick) begin
          if (age_q != AgeMin) begin
            age_d = age_q - 16'sd1;
          end
        end else if (req.boost) begin
          age_d = start_q;
        end
      end
      if (res_valid && res.was_boost) begin
        ptr_d = res.ptr_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_count_q <= CountW'(1);
      start_q       <= AgeMax;
      age_q         <= AgeMax;
      ptr_q         <= LevelW'(1);
    end else begin
      age_q <= age_d;
      ptr_q <= ptr_d;
      if (cfg_we_i && (cfg_idx_i == RegLevelCount)) begin
        level_count_q <= cfg_data_i[CountW-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == RegBoostAgeStart)) begin
        start_q <= $signed(cfg_data_i);
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_found_q <= res.found;
      out_level_q <= res.level;
      out_boost_q <= res.was_boost;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_boost_q, out_level_q, out_found_q};

endmodule

@@ hdl/ppab_alu.sv @@
// Shared step unit: conditional subtract, increment and wrapping increment.
`timescale 1ns / 1ps
module ppab_alu (
  input  ppab_pkg::ppab_alu_op_e        op_i,
  input  logic [ppab_pkg::CountW-1:0]   a_i,
  input  logic [ppab_pkg::CountW-1:0]   b_i,
  output logic [ppab_pkg::CountW-1:0]   y_o,
  output logic                          flag_o
);
  import ppab_pkg::*;

  logic [CountW-1:0] inc;
  logic [CountW-1:0] diff;
  logic              ge;

  assign inc  = a_i + CountW'(1);
  assign diff = a_i - b_i;
  assign ge   = (a_i >= b_i);

  // Select the result of the requested step
  always_comb begin
    y_o    = a_i;
    flag_o = 1'b0;
    unique case (op_i)
      AluSubGe: begin
        flag_o = ge;
        y_o    = ge ? diff : a_i;
      end
      AluInc: begin
        flag_o = (inc == b_i);
        y_o    = inc;
      end
      AluIncWrap: begin
        flag_o = (a_i == b_i);
        y_o    = flag_o ? CountW'(1) : inc;
      end
      default: begin
        flag_o = 1'b0;
        y_o    = a_i;
      end
    endcase
  end

endmodule

@@ hdl/ppab_scan.sv @@
// Scan sequencer: pointer reduction and one-level-per-cycle search.
`timescale 1ns / 1ps
module ppab_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ppab_pkg::ppab_req_t req_i,
  output logic                idle_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output ppab_pkg::ppab_res_t res_o
);
  import ppab_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMod  = 2'd1;
  localparam logic [1:0] StScan = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [MaskLevels-1:0] mask_q, mask_d;
  logic [CountW-1:0]     lim_q, lim_d;
  logic [LevelW-1:0]     lvl_q, lvl_d;
  logic [LevelW-1:0]     cnt_q, cnt_d;
  logic [LevelW-1:0]     rem_q, rem_d;
  logic                  boost_q, boost_d;
  logic                  found_q, found_d;
  logic [LevelW-1:0]     level_q, level_d;
  logic [LevelW-1:0]     ptr_q, ptr_d;

  ppab_alu_op_e      alu_op;
  logic [CountW-1:0] alu_a;
  logic [CountW-1:0] alu_y;
  logic              alu_flag;

  ppab_alu u_alu (
    .op_i   (alu_op),
    .a_i    (alu_a),
    .b_i    (lim_q),
    .y_o    (alu_y),
    .flag_o (alu_flag)
  );

  // Route the shared unit by state
  always_comb begin
    if (state_q == StMod) begin
      alu_op = AluSubGe;
      alu_a  = {1'b0, rem_q};
    end else if (boost_q) begin
      alu_op = AluIncWrap;
      alu_a  = {1'b0, lvl_q};
    end else begin
      alu_op = AluInc;
      alu_a  = {1'b0, lvl_q};
    end
  end

  // Sequence one item
  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    lim_d   = lim_q;
    lvl_d   = lvl_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    boost_d = boost_q;
    found_d = found_q;
    level_d = level_q;
    ptr_d   = ptr_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          mask_d  = req_i.mask;
          boost_d = req_i.boost;
          found_d = 1'b0;
          level_d = '0;
          lvl_d   = '0;
          cnt_d   = '0;
          rem_d   = req_i.ptr;
          ptr_d   = req_i.ptr;
          lim_d   = req_i.boost ? (req_i.n - CountW'(1)) : req_i.n;
          if (req_i.cmd == CmdTick) begin
            state_d = StFin;
          end else if (req_i.boost) begin
            state_d = StMod;
          end else begin
            state_d = StScan;
          end
        end
      end
      StMod: begin
        // Reduce the pointer below the span, then start after it
        if (alu_flag) begin
          rem_d = alu_y[LevelW-1:0];
        end else begin
          lvl_d   = rem_q + LevelW'(1);
          ptr_d   = rem_q + LevelW'(1);
          state_d = StScan;
        end
      end
      StScan: begin
        if (mask_q[lvl_q]) begin
          found_d = 1'b1;
          level_d = lvl_q;
          state_d = StFin;
        end else if (boost_q) begin
          if (cnt_q == (lim_q[LevelW-1:0] - LevelW'(1))) begin
            state_d = StFin;
          end else begin
            lvl_d = alu_y[LevelW-1:0];
            cnt_d = cnt_q + LevelW'(1);
          end
        end else begin
          if (alu_flag) begin
            state_d = StFin;
          end else begin
            lvl_d = alu_y[LevelW-1:0];
          end
        end
      end
      StFin: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Work registers carry no reset
  always_ff @(posedge clk_i) begin
    mask_q  <= mask_d;
    lim_q   <= lim_d;
    lvl_q   <= lvl_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    boost_q <= boost_d;
    found_q <= found_d;
    level_q <= level_d;
    ptr_q   <= ptr_d;
  end

  assign idle_o          = (state_q == StIdle);
  assign res_valid_o     = (state_q == StFin) && res_ready_i;
  assign res_o.found     = found_q;
  assign res_o.level     = level_q;
  assign res_o.was_boost = boost_q;
  assign res_o.ptr_next  = ptr_q;

endmodule

@@ hdl/ppab_checker.sv @@
// Port-level checks of the priority picker, bound to the top level.
`timescale 1ns / 1ps
`include "priority_pick_with_aging_boost_top_macros.svh"
module ppab_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled result holds its payload
  `PPAB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // After an accepted item the input is closed in the next cycle
  `PPAB_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // No level is reported without a find
  `PPAB_ASSERT_NOW(a_level_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[4:1] == 4'd0)

  // A boost find never lands on level 0
  `PPAB_ASSERT_NOW(a_boost_skip0, m_axis_tvalid && m_axis_tdata[5] && m_axis_tdata[0], m_axis_tdata[4:1] != 4'd0)

endmodule

bind priority_pick_with_aging_boost_top ppab_checker u_ppab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/priority_pick_with_aging_boost_top_test.sv @@
// Self-checking stream testbench for the priority level picker with aging boost.
`timescale 1ns / 1ps
module priority_pick_with_aging_boost_top_test;
  import ppab_pkg::*;

  localparam int HalfPeriod   = 2;
  localparam int ResetCycles  = 7;
  localparam int NumPhases    = 8;
  localparam int PhaseItems   = 240;
  localparam int LongHold     = 400;
  localparam int StallLimit   = 3000;
  localparam int SettleCycles = 40;

  // One result transaction as the block reports it
  typedef struct packed {
    logic              found;
    logic [LevelW-1:0] level;
    logic              was_boost;
  } pick_res_t;

  typedef enum logic {
    RowItem,
    RowReg
  } row_kind_e;

  // One line of the directed table: an item or a register write
  typedef struct packed {
    row_kind_e       kind;
    logic            sel;    // cmd for an item, register index for a write
    logic [15:0]     data;   // nonempty mask or register value
    logic            typed;  // expected result given in the table
    pick_res_t       known;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [15:0] nonempty_mask
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] found, [4:1] level, [5] was_boost, [7:6] zero

  // Shadow state of the picker
  logic [CountW-1:0]      count_q;
  logic signed [AgeW-1:0] start_q;
  logic signed [AgeW-1:0] age_q;
  logic [LevelW-1:0]      ptr_q;

  pick_res_t picks_due[$];

  int err_cnt      = 0;
  int ticks        = 0;
  int picks        = 0;
  int boosts       = 0;
  int empty_boosts = 0;
  int reg_writes   = 0;
  int stall_cycles = 0;
  int rx_wait      = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_req   = 1'b0;

  priority_pick_with_aging_boost_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Work out the result of one item and advance the shadow state
  function automatic pick_res_t pick_level(logic cmd, logic [MaskLevels-1:0] mask);
    pick_res_t   res;
    int unsigned n;
    int unsigned span;
    int unsigned lvl;
    int unsigned i;
    res = '0;
    n = (count_q == 0) ? 1 : count_q;
    if (n > MaxLevelsDef) n = MaxLevelsDef;
    if (n > MaskLevels) n = MaskLevels;
    if (cmd == CmdTick) begin
      // count one executed task, holding at the floor
      if (age_q != AgeMin) age_q = AgeW'(age_q - 1);
    end else if (n > 1 && age_q <= 0) begin
      // boost: reload the age, step the pointer, scan levels 1..n-1 after the old pointer
      span = n - 1;
      lvl = ptr_q;
      res.was_boost = 1'b1;
      ptr_q = LevelW'((ptr_q % span) + 1);
      age_q = start_q;
      for (i = 0; i < span; i++) begin
        lvl = (lvl % span) + 1;
        if (!res.found && mask[lvl]) begin
          res.found = 1'b1;
          res.level = LevelW'(lvl);
        end
      end
    end else begin
      // lowest non-empty level in use wins
      for (i = 0; i < n; i++) begin
        if (!res.found && mask[i]) begin
          res.found = 1'b1;
          res.level = LevelW'(i);
        end
      end
    end
    return res;
  endfunction

  function automatic dir_row_t reg_row(logic idx, logic [15:0] value);
    dir_row_t r;
    r = '0;
    r.kind = RowReg;
    r.sel = idx;
    r.data = value;
    return r;
  endfunction

  function automatic dir_row_t item_row(logic cmd, logic [15:0] mask);
    dir_row_t r;
    r = '0;
    r.kind = RowItem;
    r.sel = cmd;
    r.data = mask;
    return r;
  endfunction

  function automatic dir_row_t known_row(logic cmd, logic [15:0] mask, logic found,
                                         logic [LevelW-1:0] level, logic boost);
    dir_row_t r;
    r = item_row(cmd, mask);
    r.typed = 1'b1;
    r.known.found = found;
    r.known.level = level;
    r.known.was_boost = boost;
    return r;
  endfunction

  // Hold until every expected result has been taken
  task automatic drain();
    while (picks_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one register while the block is idle and mirror it in the shadow state
  task automatic write_reg(logic idx, logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegLevelCount) begin
      count_q = value[CountW-1:0];
    end else begin
      start_q = value;
      age_q = (start_q == AgeMin) ? AgeMin : AgeW'(start_q - 1);
      ptr_q = 1;
    end
    reg_writes++;
    @(posedge clk_i);
  endtask

  // Offer one item, wait for its transaction, then queue its expected result
  task automatic send_item(logic cmd, logic [15:0] mask, logic typed, pick_res_t known);
    pick_res_t due;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= mask;
    do @(posedge clk_i); while (!s_axis_tready);
    due = pick_level(cmd, mask);
    if (cmd == CmdPick) picks++;
    else ticks++;
    if (due.was_boost) boosts++;
    if (due.was_boost && !due.found) empty_boosts++;
    picks_due.push_back(typed ? known : due);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      rx_wait = LongHold;
    end
    if (rx_wait != 0) begin
      rx_wait--;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
      rx_wait = $urandom_range(0, 15);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin
    pick_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (picks_due.size() == 0) begin
        $error("result with nothing expected: tdata %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = picks_due.pop_front();
        if (m_axis_tdata[0] !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
          err_cnt++;
        end
        if (m_axis_tdata[4:1] !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, m_axis_tdata[4:1]);
          err_cnt++;
        end
        if (m_axis_tdata[5] !== want.was_boost) begin
          $error("was_boost: expected %0d, actual %0d", want.was_boost, m_axis_tdata[5]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("priority_pick_with_aging_boost_top_test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows[$];
    logic [15:0] mask;
    logic [15:0] start_val;
    int          p;
    int          k;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = RegLevelCount;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdTick;
    m_axis_tready = 1'b0;
    count_q       = 1;
    start_q       = AgeMax;
    age_q         = AgeMax;
    ptr_q         = 1;
    tx_idle_pct   = 20;
    rx_idle_pct   = 20;

    // Directed table: reset state, extremes of both registers, floor and stale pointer
    rows.push_back(known_row(CmdPick, 16'h0000, 1'b0, 4'd0, 1'b0));
    rows.push_back(known_row(CmdPick, 16'h0001, 1'b1, 4'd0, 1'b0));
    rows.push_back(known_row(CmdPick, 16'hFFFE, 1'b0, 4'd0, 1'b0));
    rows.push_back(known_row(CmdTick, 16'hFFFF, 1'b0, 4'd0, 1'b0));
    rows.push_back(reg_row(RegLevelCount, 16'd16));
    rows.push_back(known_row(CmdPick, 16'h8000, 1'b1, 4'd15, 1'b0));
    rows.push_back(known_row(CmdPick, 16'hFFFF, 1'b1, 4'd0, 1'b0));
    rows.push_back(reg_row(RegBoostAgeStart, 16'd0));
    rows.push_back(item_row(CmdPick, 16'hFFFF));
    rows.push_back(item_row(CmdPick, 16'h0000));
    rows.push_back(item_row(CmdPick, 16'h0001));
    rows.push_back(item_row(CmdTick, 16'h0000));
    rows.push_back(reg_row(RegBoostAgeStart, AgeMin));
    rows.push_back(known_row(CmdTick, 16'h0000, 1'b0, 4'd0, 1'b0));
    rows.push_back(item_row(CmdPick, 16'hAAAA));
    rows.push_back(reg_row(RegLevelCount, 16'd0));
    rows.push_back(known_row(CmdPick, 16'h0002, 1'b0, 4'd0, 1'b0));
    rows.push_back(reg_row(RegLevelCount, 16'd3));
    rows.push_back(item_row(CmdPick, 16'hFFFF));
    rows.push_back(reg_row(RegLevelCount, 16'd31));
    rows.push_back(item_row(CmdPick, 16'h8000));
    rows.push_back(reg_row(RegBoostAgeStart, AgeMax));
    rows.push_back(known_row(CmdPick, 16'h0000, 1'b0, 4'd0, 1'b0));
    rows.push_back(reg_row(RegLevelCount, 16'd2));
    rows.push_back(known_row(CmdPick, 16'h0004, 1'b0, 4'd0, 1'b0));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[j]) begin
      if (rows[j].kind == RowReg)
        write_reg(rows[j].sel, rows[j].data);
      else
        send_item(rows[j].sel, rows[j].data, rows[j].typed, rows[j].known);
    end

    // Random phases, each under its own register setting
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          write_reg(RegLevelCount, 16'd2);
          write_reg(RegBoostAgeStart, 16'd0);
          tx_idle_pct = 25;
          rx_idle_pct = 25;
        end
        1: begin
          write_reg(RegLevelCount, 16'd16);
          write_reg(RegBoostAgeStart, 16'd2);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        2: begin
          // keep the pointer from the wide setting so it starts out of range
          write_reg(RegLevelCount, 16'd3);
          tx_idle_pct = 15;
          rx_idle_pct = 30;
        end
        3: begin
          write_reg(RegLevelCount, 16'd31);
          write_reg(RegBoostAgeStart, AgeMin);
          tx_idle_pct = 30;
          rx_idle_pct = 10;
        end
        4: begin
          write_reg(RegLevelCount, 16'd1);
          write_reg(RegBoostAgeStart, AgeMax);
          tx_idle_pct = 20;
          rx_idle_pct = 20;
        end
        5: begin
          start_val = 16'($urandom_range(0, 12)) - 16'd2;
          write_reg(RegLevelCount, 16'($urandom_range(0, 31)));
          write_reg(RegBoostAgeStart, start_val);
          tx_idle_pct = 10;
          rx_idle_pct = 40;
        end
        6: begin
          write_reg(RegLevelCount, 16'd9);
          write_reg(RegBoostAgeStart, AgeMin + 16'd1);
          tx_idle_pct = 35;
          rx_idle_pct = 15;
        end
        default: begin
          write_reg(RegLevelCount, 16'($urandom_range(2, 16)));
          write_reg(RegBoostAgeStart, 16'd3);
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (k = 0; k < PhaseItems; k++) begin
        // long receiver hold-off while items keep coming
        if (p == 2 && k == 60) hold_req = 1'b1;
        // let the pipe run dry once mid-phase
        if (p == 4 && k == 120) begin
          s_axis_tvalid <= 1'b0;
          drain();
        end
        case ($urandom_range(0, 4))
          0:       mask = 16'h0000;
          1:       mask = 16'hFFFF;
          2:       mask = 16'h0001 << $urandom_range(0, 15);
          3:       mask = 16'($urandom);
          default: mask = 16'($urandom & $urandom & $urandom);
        endcase
        send_item(($urandom_range(0, 99) < 60) ? CmdPick : CmdTick, mask, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    drain();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d ticks and %0d picks across %0d register writes,",
             ticks, picks, reg_writes);
    $display("including %0d boost picks, %0d of which found no level.", boosts, empty_boosts);
    if (err_cnt == 0)
      $display("priority_pick_with_aging_boost_top_test passed");
    else
      $display("priority_pick_with_aging_boost_top_test failed");
    $finish;
  end

endmodule
